// ----- hdl/mmc_pkg.sv -----
package mmc_pkg;

   // fixed field widths
   localparam int MODE_W    = 2;
   localparam int ROW_W     = 3;
   localparam int COL_W     = 3;
   localparam int VALUE_W   = 32;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 2;

   // defaults for the top level parameters
   localparam int DEFAULT_MAX_DIM   = 8;
   localparam int DEFAULT_FRAC_BITS = 16;

   // request modes
   localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS     = 2'd2;

   // result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [ROW_W-1:0]          row_res;
      logic [COL_W-1:0]          col_res;
      logic signed [VALUE_W-1:0] value_res;
      logic                      last;
      logic                      status;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic             rd_en;
      logic             rd_first;
      logic [ROW_W-1:0] rd_row;
      logic [COL_W-1:0] rd_k;
      logic [COL_W-1:0] rd_col;
      logic             emit_res;
      logic             emit_err;
      logic [ROW_W-1:0] res_row;
      logic [COL_W-1:0] res_col;
      logic             res_last;
   } mmc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } mmc_sts_type;

endpackage

// ----- hdl/mmc_ram.sv -----
module mmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mmc_ctrl.sv -----
module mmc_ctrl #(
   parameter int MAX_DIM = mmc_pkg::DEFAULT_MAX_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mmc_pkg::req_word_type            req_word,
   input  logic                             csr_we,
   input  logic [mmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mmc_pkg::DIM_W-1:0]        csr_wdata,
   input  mmc_pkg::mmc_sts_type             sts,
   output mmc_pkg::mmc_cmd_type             cmd
);
   import mmc_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [DIM_W-1:0] a_rows_ff, inner_ff, b_cols_ff;
   logic [DIM_W-1:0] dim_clamped;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ROW_W-1:0] err_row_ff, err_row_in;
   logic [COL_W-1:0] err_col_ff, err_col_in;
   logic             accept;
   logic             in_range;
   logic [DIM_W-1:0] rlim, clim;
   logic             i_last, j_last, k_last;

   // size registers saturate into 1..MAX_DIM
   always_comb begin
      priority if (csr_wdata == '0) begin
         dim_clamped = DIM_W'(1);
      end else if (csr_wdata > DIM_W'(MAX_DIM)) begin
         dim_clamped = DIM_W'(MAX_DIM);
      end else begin
         dim_clamped = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= DIM_W'(MAX_DIM);
         inner_ff  <= DIM_W'(MAX_DIM);
         b_cols_ff <= DIM_W'(MAX_DIM);
      end else if (csr_we) begin
         if (csr_index == REG_A_ROWS) begin
            a_rows_ff <= dim_clamped;
         end
         if (csr_index == REG_INNER_SIZE) begin
            inner_ff <= dim_clamped;
         end
         if (csr_index == REG_B_COLS) begin
            b_cols_ff <= dim_clamped;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign rlim     = (req_word.mode == MODE_WRITE_A) ? a_rows_ff : inner_ff;
   assign clim     = (req_word.mode == MODE_WRITE_A) ? inner_ff : b_cols_ff;
   assign in_range = (DIM_W'(req_word.row) < rlim) && (DIM_W'(req_word.col) < clim);

   assign i_last = (DIM_W'(i_ff) + DIM_W'(1)) == a_rows_ff;
   assign j_last = (DIM_W'(j_ff) + DIM_W'(1)) == b_cols_ff;
   assign k_last = (DIM_W'(k_ff) + DIM_W'(1)) == inner_ff;

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      err_row_in = err_row_ff;
      err_col_in = err_col_ff;

      cmd          = '0;
      cmd.rd_row   = ROW_W'(i_ff);
      cmd.rd_k     = COL_W'(k_ff);
      cmd.rd_col   = COL_W'(j_ff);
      cmd.rd_first = (k_ff == '0);
      cmd.res_row  = ROW_W'(i_ff);
      cmd.res_col  = COL_W'(j_ff);
      cmd.res_last = i_last && j_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_word.mode == MODE_WRITE_A ||
                            req_word.mode == MODE_WRITE_B) begin
                  if (in_range) begin
                     cmd.wr_a = (req_word.mode == MODE_WRITE_A);
                     cmd.wr_b = (req_word.mode == MODE_WRITE_B);
                  end else begin
                     err_row_in = req_word.row;
                     err_col_in = req_word.col;
                     state_in   = ST_ERR;
                  end
               end else if (req_word.mode == MODE_COMPUTE) begin
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RUN: begin
            cmd.rd_en = 1'b1;
            if (k_last) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_res = 1'b1;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = ST_RUN;
                  end
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_RUN;
               end
            end
         end
         ST_ERR: begin
            cmd.res_row = err_row_ff;
            cmd.res_col = err_col_ff;
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      err_row_ff <= err_row_in;
      err_col_ff <= err_col_in;
   end

endmodule

// ----- hdl/mmc_datapath.sv -----
module mmc_datapath #(
   parameter int MAX_DIM   = mmc_pkg::DEFAULT_MAX_DIM,
   parameter int FRAC_BITS = mmc_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mmc_pkg::req_word_type req_word,
   input  mmc_pkg::mmc_cmd_type  cmd,
   output mmc_pkg::mmc_sts_type  sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mmc_pkg::rsp_word_type rsp_word
);
   import mmc_pkg::*;

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PROD_W = 2 * VALUE_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

   localparam logic [ACC_W-1:0]        HALF    = (ACC_W'(1) << FRAC_BITS) >> 1;
   localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) << (VALUE_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   logic [ADDR_W-1:0]          wr_addr, a_raddr, b_raddr;
   logic [VALUE_W-1:0]         a_rdata, b_rdata;
   logic [DEPTH-1:0]           a_vld_ff, a_vld_in, b_vld_ff, b_vld_in;
   logic                       a_ok_ff, b_ok_ff;
   logic                       rd_vld_ff, rd_first_ff;
   logic signed [VALUE_W-1:0]  a_val, b_val;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_vld_ff, prod_first_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    rnd_sum, shifted;
   logic signed [VALUE_W-1:0]  sat_val;
   logic                       rsp_valid_ff;
   rsp_word_type               rsp_word_ff, rsp_word_in;

   assign wr_addr = ADDR_W'(req_word.row[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                  + ADDR_W'(req_word.col[IDX_W-1:0]);
   assign a_raddr = ADDR_W'(cmd.rd_row[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                  + ADDR_W'(cmd.rd_k[IDX_W-1:0]);
   assign b_raddr = ADDR_W'(cmd.rd_k[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                  + ADDR_W'(cmd.rd_col[IDX_W-1:0]);

   mmc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (cmd.wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_word.value),
      .rd_en   (cmd.rd_en),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   mmc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (cmd.wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_word.value),
      .rd_en   (cmd.rd_en),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   // entries never written since reset read as zero
   always_comb begin
      a_vld_in = a_vld_ff;
      b_vld_in = b_vld_ff;
      if (cmd.wr_a) begin
         a_vld_in[wr_addr] = 1'b1;
      end
      if (cmd.wr_b) begin
         b_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff    <= '0;
         b_vld_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         a_vld_ff    <= a_vld_in;
         b_vld_ff    <= b_vld_in;
         rd_vld_ff   <= cmd.rd_en;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   assign a_val   = a_ok_ff ? signed'(a_rdata) : '0;
   assign b_val   = b_ok_ff ? signed'(b_rdata) : '0;
   assign prod_in = a_val * b_val;
   assign acc_in  = (prod_first_ff ? '0 : acc_ff) + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         a_ok_ff     <= a_vld_ff[a_raddr];
         b_ok_ff     <= b_vld_ff[b_raddr];
         rd_first_ff <= cmd.rd_first;
      end
      if (rd_vld_ff) begin
         prod_ff       <= prod_in;
         prod_first_ff <= rd_first_ff;
      end
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // round half up, then saturate
   assign rnd_sum = acc_ff + HALF;
   assign shifted = rnd_sum >>> FRAC_BITS;

   always_comb begin
      priority if (shifted > SAT_MAX) begin
         sat_val = SAT_MAX[VALUE_W-1:0];
      end else if (shifted < SAT_MIN) begin
         sat_val = SAT_MIN[VALUE_W-1:0];
      end else begin
         sat_val = shifted[VALUE_W-1:0];
      end
   end

   always_comb begin
      rsp_word_in.row_res = cmd.res_row;
      rsp_word_in.col_res = cmd.res_col;
      if (cmd.emit_err) begin
         rsp_word_in.value_res = '0;
         rsp_word_in.last      = 1'b1;
         rsp_word_in.status    = STATUS_RANGE;
      end else begin
         rsp_word_in.value_res = sat_val;
         rsp_word_in.last      = cmd.res_last;
         rsp_word_in.status    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_res || cmd.emit_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_res || cmd.emit_err) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign sts.pipe_busy = rd_vld_ff || prod_vld_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hdl/matrix_multiply_core.sv -----
// load words (write a or b) are written to their ram when accepted; an out of range load
// answers with a range status word when the output reg is free; compute: each element is a
// serial mac over the inner dimension, one a/b ram read per cycle, plus read/mul/acc drain
// a compute word holds req_ready low until all a_rows * b_cols elements are in the output reg
// reset (synchronous, active high) sets all sizes to MAX_DIM and marks both stores empty,
// so unwritten elements read as zero; no clearing pass is needed
module matrix_multiply_core #(
   parameter int MAX_DIM   = mmc_pkg::DEFAULT_MAX_DIM,
   parameter int FRAC_BITS = mmc_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mmc_pkg::req_word_type         req_word,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mmc_pkg::rsp_word_type         rsp_word,
   // size registers
   input  logic                          csr_we,
   input  logic [mmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mmc_pkg::DIM_W-1:0]     csr_wdata
);
   import mmc_pkg::*;

   mmc_cmd_type cmd;
   mmc_sts_type sts;

   // controller: size registers, range check, i/j/k loop counters
   mmc_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: a/b rams, multiply, wide accumulate, round/saturate, output reg
   mmc_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // a result word must never overwrite one still waiting on the output
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_res || cmd.emit_err) |-> sts.out_free)
      else $error("result emitted while output reg still full");

   // a product element leaves only after the mac pipeline is empty
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_res |-> !sts.pipe_busy)
      else $error("result emitted before accumulation finished");

   // the block is ready only when no mac work is left in flight
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!sts.pipe_busy && !cmd.rd_en))
      else $error("ready while multiply pipeline busy");

   // after an error word is loaded the block returns to taking words
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_err |=> req_ready)
      else $error("not ready after error word");

endmodule
